>>> src/modbus_rtu_crc_framer_checker_top_assert.svh
// assertion macros for the checker in mrcf_checker.sv
// each macro expects signals named clk and rst in the enclosing scope
`ifndef MODBUS_RTU_CRC_FRAMER_CHECKER_TOP_ASSERT_SVH
`define MODBUS_RTU_CRC_FRAMER_CHECKER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MRCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MRCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/mrcf_pkg.sv
// ----------------------------------------------------------------------------
// mrcf_pkg
// Types, codes, constants and the CRC-16 byte fold shared by the Modbus RTU
// framer/checker modules.
// ----------------------------------------------------------------------------
package mrcf_pkg;

  // frame size default for the top level parameter
  localparam int MAX_FRAME_BYTES_DEF = 256;

  // crc constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam int          CRC_BYTES    = 2;
  localparam int          MIN_RX_BYTES = 4;

  // result field widths
  localparam int LEN_W = 9;

  // result queue sizing
  localparam int PUSH_MAX    = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int PUSH_W      = $clog2(PUSH_MAX + 1);

  // register file
  localparam int          APB_DATA_W        = 32;
  localparam int          APB_ADDR_W        = 3;
  localparam logic        REG_RX_COPY_LIMIT = 1'b0;
  localparam logic [7:0]  RX_COPY_LIMIT_RST = 8'd254;

  // request codes
  localparam logic REQ_TX = 1'b0;
  localparam logic REQ_RX = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_RX     = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // receive status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_CRC   = 2'd2;
  localparam logic [1:0] ST_LONG  = 2'd3;

  // one result item
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic             last;
    logic [1:0]       status;
    logic [LEN_W-1:0] len;
    logic [15:0]      crc;
  } res_t;

  // fold one byte into a reflected modbus crc
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> src/modbus_rtu_crc_framer_checker_top.sv
// ----------------------------------------------------------------------------
// modbus_rtu_crc_framer_checker_top
// Modbus RTU CRC-16 framer for transmit bytes and frame checker for received
// bytes, with an APB register for the receive copy limit.
// ----------------------------------------------------------------------------
// Usage: one frame byte is accepted per cycle into an input register while
// in_ready is high, and is processed from there in a single pass (one 8-step
// CRC fold); its results are registered in the result queue before they are
// offered. Each byte yields zero to three results, which go into a four-entry
// result queue drained at one result per cycle while out_ready is high; a byte
// whose results do not fit in the free queue slots waits in the input register
// until enough results have been drained.
// Transmit frames carry at most MAX_FRAME_BYTES-2 payload bytes; received
// frames are checked over at most MAX_FRAME_BYTES bytes. Write rx_copy_limit
// only while no transaction is in flight.
module modbus_rtu_crc_framer_checker_top
  import mrcf_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [7:0]            data_byte,
  input  logic                  is_last,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_byte,
  output logic                  out_last,
  output logic [1:0]            status,
  output logic [LEN_W-1:0]      frame_length,
  output logic [15:0]           crc_value,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int              CNT_W  = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [CNT_W-1:0] TX_MAX = CNT_W'(MAX_FRAME_BYTES - CRC_BYTES);
  localparam logic [CNT_W-1:0] RX_MAX = CNT_W'(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0] C_CRCB = CNT_W'(CRC_BYTES);
  localparam logic [CNT_W-1:0] C_MINR = CNT_W'(MIN_RX_BYTES);

  // register port
  logic [7:0] rx_copy_limit;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_RX_COPY_LIMIT);
  assign prdata  = reg_sel ? APB_DATA_W'(rx_copy_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_copy_limit <= RX_COPY_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      rx_copy_limit <= pwdata[7:0];
    end
  end

  // input register
  logic       ireg_valid;
  logic       ireg_type;
  logic [7:0] ireg_data;
  logic       ireg_last;
  logic       fire;

  assign in_ready = !ireg_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_ready) begin
      ireg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ireg_type <= req_type;
      ireg_data <= data_byte;
      ireg_last <= is_last;
    end
  end

  // frame state
  logic [15:0]      tx_crc, tx_crc_next;
  logic [CNT_W-1:0] tx_count, tx_count_next;
  logic [15:0]      rx_crc, rx_crc_next;
  logic [CNT_W-1:0] rx_count, rx_count_next;
  logic [7:0]       rx_hold [2];
  logic [7:0]       rx_hold_next [2];

  // result packing
  logic [PUSH_W-1:0] push_n;
  res_t              push_item [PUSH_MAX];
  logic [QCNT_W-1:0] free_slots;
  res_t              head;

  assign fire = ireg_valid && (QCNT_W'(push_n) <= free_slots);

  // single pass over the registered byte
  always_comb begin
    logic             tx_ok;
    logic [15:0]      tx_crc1;
    logic [CNT_W-1:0] tx_cnt1;
    logic             tx_over;
    logic [1:0]       tx_st;
    logic [CNT_W-1:0] tx_len;
    logic             rx_in;
    logic             rx_shift_out;
    logic [CNT_W-1:0] rx_idx;
    logic             rx_deliver;
    logic [15:0]      rx_crc1;
    logic [CNT_W-1:0] rx_cnt1;
    logic [CNT_W-1:0] rx_used;
    logic [CNT_W-1:0] rx_len;
    logic [1:0]       rx_st;
    res_t             r_tx, r_lo, r_hi, r_pl, r_st;

    // transmit path
    tx_ok   = (tx_count < TX_MAX);
    tx_crc1 = tx_ok ? crc_fold(tx_crc, ireg_data) : tx_crc;
    tx_cnt1 = tx_ok ? tx_count + CNT_W'(1) : TX_MAX + CNT_W'(1);
    tx_over = (tx_cnt1 > TX_MAX);
    tx_st   = tx_over ? ST_LONG : ST_OK;
    tx_len  = tx_over ? TX_MAX : tx_cnt1;
    r_tx    = '{kind: KIND_TX, data: ireg_data, last: 1'b0, status: ST_OK,
                len: LEN_W'(tx_cnt1), crc: tx_crc1};
    r_lo    = '{kind: KIND_TX, data: tx_crc1[7:0], last: 1'b0, status: tx_st,
                len: LEN_W'(tx_len), crc: tx_crc1};
    r_hi    = '{kind: KIND_TX, data: tx_crc1[15:8], last: 1'b1, status: tx_st,
                len: LEN_W'(tx_len), crc: tx_crc1};

    // receive path: byte leaving the two-byte hold line
    rx_in        = (rx_count < RX_MAX);
    rx_shift_out = rx_in && (rx_count >= C_CRCB);
    rx_idx       = rx_count - C_CRCB;
    rx_deliver   = rx_shift_out &&
                   ({8'h00, rx_idx} < {{CNT_W{1'b0}}, rx_copy_limit});
    rx_crc1      = rx_shift_out ? crc_fold(rx_crc, rx_hold[0]) : rx_crc;
    rx_cnt1      = rx_in ? rx_count + CNT_W'(1) : RX_MAX + CNT_W'(1);
    rx_hold_next[0] = rx_in ? rx_hold[1] : rx_hold[0];
    rx_hold_next[1] = rx_in ? ireg_data  : rx_hold[1];
    rx_used      = (rx_cnt1 > RX_MAX) ? RX_MAX : rx_cnt1;
    rx_len       = (rx_used >= C_CRCB) ? rx_used - C_CRCB : '0;
    if (rx_cnt1 > RX_MAX) begin
      rx_st = ST_LONG;
    end else if (rx_cnt1 < C_MINR) begin
      rx_st = ST_SHORT;
    end else if ({rx_hold_next[1], rx_hold_next[0]} == rx_crc1) begin
      rx_st = ST_OK;
    end else begin
      rx_st = ST_CRC;
    end
    r_pl = '{kind: KIND_RX, data: rx_hold[0], last: 1'b0, status: ST_OK,
             len: LEN_W'(rx_idx + CNT_W'(1)), crc: rx_crc1};
    r_st = '{kind: KIND_STATUS, data: 8'h00, last: 1'b1, status: rx_st,
             len: LEN_W'(rx_len), crc: rx_crc1};

    // defaults hold state
    tx_crc_next   = tx_crc;
    tx_count_next = tx_count;
    rx_crc_next   = rx_crc;
    rx_count_next = rx_count;
    push_n        = '0;
    push_item[0]  = r_tx;
    push_item[1]  = r_lo;
    push_item[2]  = r_hi;

    if (ireg_type == REQ_TX) begin
      tx_crc_next   = ireg_last ? CRC_INIT : tx_crc1;
      tx_count_next = ireg_last ? '0 : tx_cnt1;
      if (tx_ok) begin
        push_n = PUSH_W'(ireg_last ? 3 : 1);
      end else begin
        push_n       = PUSH_W'(ireg_last ? 2 : 0);
        push_item[0] = r_lo;
        push_item[1] = r_hi;
      end
    end else begin
      rx_crc_next   = ireg_last ? CRC_INIT : rx_crc1;
      rx_count_next = ireg_last ? '0 : rx_cnt1;
      if (rx_deliver) begin
        push_item[0] = r_pl;
        push_item[1] = r_st;
        push_n       = PUSH_W'(ireg_last ? 2 : 1);
      end else begin
        push_item[0] = r_st;
        push_n       = PUSH_W'(ireg_last ? 1 : 0);
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_crc   <= CRC_INIT;
      tx_count <= '0;
      rx_crc   <= CRC_INIT;
      rx_count <= '0;
    end else if (fire) begin
      tx_crc   <= tx_crc_next;
      tx_count <= tx_count_next;
      rx_crc   <= rx_crc_next;
      rx_count <= rx_count_next;
    end
  end

  // hold line, only meaningful once written in the current frame
  always_ff @(posedge clk) begin
    if (fire && (ireg_type == REQ_RX)) begin
      rx_hold[0] <= rx_hold_next[0];
      rx_hold[1] <= rx_hold_next[1];
    end
  end

  // result queue
  mrcf_res_queue u_res_queue (
    .clk        (clk),
    .rst        (rst),
    .push_n     (fire ? push_n : '0),
    .push_item  (push_item),
    .free_slots (free_slots),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .head       (head)
  );

  assign out_kind     = head.kind;
  assign out_byte     = head.data;
  assign out_last     = head.last;
  assign status       = head.status;
  assign frame_length = head.len;
  assign crc_value    = head.crc;

endmodule

>>> src/mrcf_res_queue.sv
// ----------------------------------------------------------------------------
// mrcf_res_queue
// Shifting result queue: takes up to three results per cycle in order and
// presents the oldest one at the output handshake.
// ----------------------------------------------------------------------------
module mrcf_res_queue
  import mrcf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [PUSH_W-1:0] push_n,
  input  res_t              push_item [PUSH_MAX],
  output logic [QCNT_W-1:0] free_slots,
  output logic              out_valid,
  input  logic              out_ready,
  output res_t              head
);

  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic [QCNT_W-1:0] kept;
  logic              pop;
  res_t              slot      [QUEUE_DEPTH];
  res_t              slot_next [QUEUE_DEPTH];

  // output side
  assign out_valid  = (count != '0);
  assign head       = slot[0];
  assign pop        = out_valid && out_ready;
  assign kept       = count - QCNT_W'(pop);
  assign free_slots = QCNT_W'(QUEUE_DEPTH) - kept;
  assign count_next = kept + QCNT_W'(push_n);

  // shift down on pop, append new results behind the kept ones
  always_comb begin
    logic [QCNT_W-1:0] off;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      off          = QCNT_W'(i) - kept;
      slot_next[i] = slot[i];
      if (QCNT_W'(i) < kept) begin
        if (pop && (i + 1 < QUEUE_DEPTH)) begin
          slot_next[i] = slot[(i + 1) % QUEUE_DEPTH];
        end
      end else if (off < QCNT_W'(push_n)) begin
        slot_next[i] = push_item[off[PUSH_W-1:0]];
      end
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot[i] <= slot_next[i];
    end
  end

endmodule

>>> src/mrcf_checker.sv
// ----------------------------------------------------------------------------
// mrcf_checker
// Port-level checks on the result stream of the Modbus RTU framer/checker,
// bound to the top level.
// ----------------------------------------------------------------------------
`include "modbus_rtu_crc_framer_checker_top_assert.svh"

module mrcf_checker
  import mrcf_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       out_kind,
  input logic [7:0]       out_byte,
  input logic             out_last,
  input logic [1:0]       status,
  input logic [LEN_W-1:0] frame_length,
  input logic [15:0]      crc_value
);

  // the result kind is never the unused code
  `MRCF_ASSERT_NOW(a_kind_known, out_valid, out_kind != 2'd3, "unused result kind")

  // a receive status transaction always closes the frame and carries no byte
  `MRCF_ASSERT_NOW(a_status_closes, out_valid && (out_kind == KIND_STATUS), out_last && (out_byte == 8'h00), "status transaction not final or carries a byte")

  // delivered payload is never final, ok, and never counted as zero
  `MRCF_ASSERT_NOW(a_payload_shape, out_valid && (out_kind == KIND_RX), !out_last && (status == ST_OK) && (frame_length != '0), "malformed payload transaction")

  // a stalled result holds its contents
  `MRCF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(crc_value) && $stable(out_kind), "stalled result changed")

endmodule

bind modbus_rtu_crc_framer_checker_top mrcf_checker u_mrcf_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_kind     (out_kind),
  .out_byte     (out_byte),
  .out_last     (out_last),
  .status       (status),
  .frame_length (frame_length),
  .crc_value    (crc_value)
);

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives transmit and receive frame bytes into the Modbus RTU CRC framer and
// checker, compares every result against a CRC-16 frame model kept in step
// with the accepted bytes, and exercises the copy limit register over APB.
// ----------------------------------------------------------------------------
module testbench;
  import mrcf_pkg::*;

  localparam int          FRAME_MAX      = MAX_FRAME_BYTES_DEF;
  localparam int          TX_PAYLOAD_MAX = FRAME_MAX - CRC_BYTES;
  localparam int          QUIET_CYCLES   = 8;
  localparam int          LONG_HOLD      = 40;
  localparam int          STALL_LIMIT    = 2000;
  localparam int          SHOWN_MAX      = 40;
  localparam logic [APB_ADDR_W-1:0] COPY_LIMIT_ADDR = APB_ADDR_W'(4 * REG_RX_COPY_LIMIT);
  localparam logic [APB_ADDR_W-1:0] SPARE_REG_ADDR  = APB_ADDR_W'(4 * (REG_RX_COPY_LIMIT + 1));

  // one row of the directed stimulus, repeated reps times
  typedef struct packed {
    logic       req;
    logic [7:0] data;
    logic       ramp;
    logic [8:0] reps;
    logic       last;
    logic       typed;
    logic [1:0] st;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic req_type;
  logic [7:0] data_byte;
  logic is_last;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic out_last;
  logic [1:0] status;
  logic [LEN_W-1:0] frame_length;
  logic [15:0] crc_value;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  // frame model state and the results it still owes
  logic [15:0] tx_sum = CRC_INIT;
  int unsigned tx_taken = 0;
  logic [15:0] rx_sum = CRC_INIT;
  int unsigned rx_seen = 0;
  logic [7:0] rx_tail [0:1];
  logic [7:0] copy_cap = RX_COPY_LIMIT_RST;
  res_t framer_results_q [$];

  int unsigned mismatches = 0;
  bit feeder_idling = 1'b1;
  bit sink_idling = 1'b1;
  bit sink_hold_req = 1'b0;

  // directed frames: known request frame both ways, short frames, a bad crc
  step_row_t plan [0:18] = '{
    '{REQ_TX, 8'h01, 1'b0, 9'd1,   1'b0, 1'b0, ST_OK},
    '{REQ_TX, 8'h03, 1'b0, 9'd1,   1'b0, 1'b0, ST_OK},
    '{REQ_TX, 8'h00, 1'b0, 9'd3,   1'b0, 1'b0, ST_OK},
    '{REQ_TX, 8'h01, 1'b0, 9'd1,   1'b1, 1'b1, ST_OK},
    '{REQ_RX, 8'h01, 1'b0, 9'd1,   1'b0, 1'b0, ST_OK},
    '{REQ_RX, 8'h03, 1'b0, 9'd1,   1'b0, 1'b0, ST_OK},
    '{REQ_RX, 8'h00, 1'b0, 9'd3,   1'b0, 1'b0, ST_OK},
    '{REQ_RX, 8'h01, 1'b0, 9'd1,   1'b0, 1'b0, ST_OK},
    '{REQ_RX, 8'h84, 1'b0, 9'd1,   1'b0, 1'b0, ST_OK},
    '{REQ_RX, 8'h0A, 1'b0, 9'd1,   1'b1, 1'b1, ST_OK},
    '{REQ_RX, 8'hFF, 1'b0, 9'd1,   1'b1, 1'b1, ST_SHORT},
    '{REQ_RX, 8'h00, 1'b0, 9'd1,   1'b0, 1'b0, ST_OK},
    '{REQ_RX, 8'hFF, 1'b0, 9'd1,   1'b1, 1'b1, ST_SHORT},
    '{REQ_RX, 8'h00, 1'b0, 9'd1,   1'b0, 1'b0, ST_OK},
    '{REQ_RX, 8'hFF, 1'b0, 9'd1,   1'b0, 1'b0, ST_OK},
    '{REQ_RX, 8'h00, 1'b0, 9'd1,   1'b1, 1'b1, ST_SHORT},
    '{REQ_TX, 8'hFF, 1'b0, 9'd1,   1'b1, 1'b1, ST_OK},
    '{REQ_RX, 8'hFF, 1'b0, 9'd3,   1'b0, 1'b0, ST_OK},
    '{REQ_RX, 8'h00, 1'b0, 9'd1,   1'b1, 1'b0, ST_OK}
  };

  modbus_rtu_crc_framer_checker_top #(
    .MAX_FRAME_BYTES(FRAME_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .data_byte(data_byte),
    .is_last(is_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_byte(out_byte),
    .out_last(out_last),
    .status(status),
    .frame_length(frame_length),
    .crc_value(crc_value),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // modbus crc, one data bit folded in per shift
  function automatic logic [15:0] modbus_fold(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    logic fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic res_t pack_result(input logic [1:0] kind, input logic [7:0] data,
                                       input logic last, input logic [1:0] st,
                                       input int unsigned len, input logic [15:0] sum);
    res_t r;
    r.kind = kind;
    r.data = data;
    r.last = last;
    r.status = st;
    r.len = LEN_W'(len);
    r.crc = sum;
    return r;
  endfunction

  // advance the frame model by one accepted byte and queue its results
  function automatic void run_crc_framer(input logic r, input logic [7:0] b, input logic l);
    int unsigned used;
    int unsigned len;
    logic [1:0] st;
    if (r == REQ_TX) begin
      if (tx_taken < TX_PAYLOAD_MAX) begin
        tx_sum = modbus_fold(tx_sum, b);
        tx_taken++;
        framer_results_q.push_back(pack_result(KIND_TX, b, 1'b0, ST_OK, tx_taken, tx_sum));
      end else begin
        tx_taken = TX_PAYLOAD_MAX + 1;
      end
      if (l) begin
        st = (tx_taken > TX_PAYLOAD_MAX) ? ST_LONG : ST_OK;
        len = (tx_taken > TX_PAYLOAD_MAX) ? TX_PAYLOAD_MAX : tx_taken;
        framer_results_q.push_back(pack_result(KIND_TX, tx_sum[7:0], 1'b0, st, len, tx_sum));
        framer_results_q.push_back(pack_result(KIND_TX, tx_sum[15:8], 1'b1, st, len, tx_sum));
        tx_sum = CRC_INIT;
        tx_taken = 0;
      end
    end else begin
      // bytes leave the two-byte hold line into the crc
      if (rx_seen < FRAME_MAX) begin
        if (rx_seen >= CRC_BYTES) begin
          rx_sum = modbus_fold(rx_sum, rx_tail[0]);
          if (rx_seen - CRC_BYTES < copy_cap) begin
            framer_results_q.push_back(pack_result(KIND_RX, rx_tail[0], 1'b0, ST_OK,
                                                   rx_seen - CRC_BYTES + 1, rx_sum));
          end
        end
        rx_tail[0] = rx_tail[1];
        rx_tail[1] = b;
        rx_seen++;
      end else begin
        rx_seen = FRAME_MAX + 1;
      end
      if (l) begin
        used = (rx_seen > FRAME_MAX) ? FRAME_MAX : rx_seen;
        len = (used >= CRC_BYTES) ? used - CRC_BYTES : 0;
        if (rx_seen > FRAME_MAX) begin
          st = ST_LONG;
        end else if (rx_seen < MIN_RX_BYTES) begin
          st = ST_SHORT;
        end else begin
          st = ({rx_tail[1], rx_tail[0]} == rx_sum) ? ST_OK : ST_CRC;
        end
        framer_results_q.push_back(pack_result(KIND_STATUS, 8'h00, 1'b1, st, len, rx_sum));
        rx_sum = CRC_INIT;
        rx_seen = 0;
      end
    end
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      return 0;
    end else if (roll < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got, input int unsigned want);
    mismatches++;
    if (mismatches <= SHOWN_MAX) begin
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    end
  endtask

  // one apb transfer, setup then access, then the bus returns to idle
  task automatic apb_cycle(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] wdata,
                           output logic [APB_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_copy_limit();
    logic [APB_DATA_W-1:0] rd;
    apb_cycle(1'b0, COPY_LIMIT_ADDR, '0, rd);
    if (rd[7:0] !== copy_cap) begin
      note_mismatch("rx_copy_limit readback", rd[7:0], copy_cap);
    end
  endtask

  task automatic set_copy_limit(input logic [APB_ADDR_W-1:0] addr, input logic [7:0] value);
    logic [APB_DATA_W-1:0] rd;
    apb_cycle(1'b1, addr, APB_DATA_W'(value), rd);
    if (addr == COPY_LIMIT_ADDR) begin
      copy_cap = value;
    end
    check_copy_limit();
  endtask

  // present one byte until accepted; a pinned status overrides the frame end
  task automatic offer(input logic r, input logic [7:0] b, input logic l,
                       input logic typed, input logic [1:0] st);
    int unsigned gap;
    int unsigned tail_n;
    in_valid <= 1'b1;
    req_type <= r;
    data_byte <= b;
    is_last <= l;
    do @(posedge clk); while (!in_ready);
    run_crc_framer(r, b, l);
    if (typed) begin
      tail_n = (r == REQ_TX) ? 2 : 1;
      for (int k = 1; k <= tail_n; k++) begin
        framer_results_q[framer_results_q.size() - k].status = st;
      end
    end
    gap = feeder_idling ? idle_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and let every owed result come out
  task automatic drain_and_wait();
    in_valid <= 1'b0;
    do @(posedge clk); while (framer_results_q.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // random tx and rx frames, mostly well formed, interleaved byte by byte
  task automatic random_traffic(input int unsigned budget, input bit do_hold, input bit do_pause);
    logic [7:0] tx_bytes [$];
    logic [7:0] rx_bytes [$];
    logic [15:0] sum;
    logic [7:0] b;
    int unsigned sent;
    int unsigned frames;
    int unsigned shape;
    int unsigned form;
    int unsigned pos;
    bit pick_rx;
    sent = 0;
    frames = 0;
    while (sent < budget) begin
      if (do_hold && frames == 1) begin
        sink_hold_req = 1'b1;
      end
      if (do_pause && frames == 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (framer_results_q.size() != 0);
      end
      shape = $urandom_range(0, 9);
      // transmit frame
      if (shape < 3 || shape >= 7) begin
        repeat ($urandom_range(1, 12)) tx_bytes.push_back(pick_byte());
      end
      // receive frame: good, corrupted, short noise or long noise
      if (shape >= 3) begin
        form = $urandom_range(0, 9);
        if (form <= 7) begin
          sum = CRC_INIT;
          repeat ($urandom_range(0, 12)) begin
            b = pick_byte();
            sum = modbus_fold(sum, b);
            rx_bytes.push_back(b);
          end
          rx_bytes.push_back(sum[7:0]);
          rx_bytes.push_back(sum[15:8]);
          if (form == 7) begin
            pos = $urandom_range(0, rx_bytes.size() - 1);
            rx_bytes[pos] = rx_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
          end
        end else begin
          repeat ((form == 8) ? $urandom_range(1, 3) : $urandom_range(4, 10)) begin
            rx_bytes.push_back(pick_byte());
          end
        end
      end
      while (tx_bytes.size() != 0 || rx_bytes.size() != 0) begin
        pick_rx = (tx_bytes.size() == 0) || (rx_bytes.size() != 0 && $urandom_range(0, 1) == 1);
        if (pick_rx) begin
          b = rx_bytes.pop_front();
          offer(REQ_RX, b, rx_bytes.size() == 0, 1'b0, ST_OK);
        end else begin
          b = tx_bytes.pop_front();
          offer(REQ_TX, b, tx_bytes.size() == 0, 1'b0, ST_OK);
        end
        sent++;
      end
      frames++;
    end
  endtask

  // result side: random back-pressure plus one long hold on request
  initial begin : result_sink
    int unsigned stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (sink_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        sink_hold_req = 1'b0;
      end else if (sink_idling) begin
        stall = idle_gap();
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // compare each result transaction with the oldest owed result
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst === 1'b0 && out_valid && out_ready) begin
      if (framer_results_q.size() == 0) begin
        note_mismatch("result with nothing owed, kind", out_kind, 0);
      end else begin
        want = framer_results_q.pop_front();
        if (out_kind !== want.kind) note_mismatch("out_kind", out_kind, want.kind);
        if (out_byte !== want.data) note_mismatch("out_byte", out_byte, want.data);
        if (out_last !== want.last) note_mismatch("out_last", out_last, want.last);
        if (status !== want.status) note_mismatch("status", status, want.status);
        if (frame_length !== want.len) note_mismatch("frame_length", frame_length, want.len);
        if (crc_value !== want.crc) note_mismatch("crc_value", crc_value, want.crc);
      end
    end
  end

  // end the run when no transaction moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst !== 1'b0 || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned j;
    logic closing;
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= REQ_TX;
    data_byte <= 8'h00;
    is_last <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_copy_limit();

    // directed frames at the reset copy limit
    foreach (plan[i]) begin
      for (j = 0; j < plan[i].reps; j++) begin
        closing = (j == plan[i].reps - 1);
        offer(plan[i].req, plan[i].ramp ? plan[i].data + 8'(j) : plan[i].data,
              plan[i].last && closing, plan[i].typed && closing, plan[i].st);
      end
    end
    drain_and_wait();

    // nothing delivered, with a long hold on the result side
    set_copy_limit(COPY_LIMIT_ADDR, 8'h00);
    random_traffic(30, 1'b1, 1'b0);
    drain_and_wait();

    // full limit, both sides streaming with no gaps
    feeder_idling = 1'b0;
    sink_idling = 1'b0;
    set_copy_limit(COPY_LIMIT_ADDR, 8'hFF);
    random_traffic(15, 1'b0, 1'b0);
    drain_and_wait();

    // unmapped register must be ignored, then a tight limit
    feeder_idling = 1'b1;
    sink_idling = 1'b1;
    set_copy_limit(SPARE_REG_ADDR, 8'h05);
    set_copy_limit(COPY_LIMIT_ADDR, 8'h03);
    random_traffic(25, 1'b0, 1'b1);
    drain_and_wait();

    set_copy_limit(COPY_LIMIT_ADDR, 8'($urandom_range(1, 254)));
    random_traffic(30, 1'b1, 1'b1);
    drain_and_wait();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/mrcf_pkg.sv
src/mrcf_res_queue.sv
src/modbus_rtu_crc_framer_checker_top.sv
src/mrcf_checker.sv
test/testbench.sv
